### design/rcbpm_pkg.sv
// Shared widths, codes and types of the range cache block presence map.
package rcbpm_pkg;

	localparam int MODE_W      = 2;
	localparam int POS_W       = 40;
	localparam int OBJ_SIZE_W  = 41;
	localparam int BLK_SIZE_W  = 33;
	localparam int BLK_COUNT_W = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 41;

	localparam int MAX_BLOCKS_DEF = 4096;

	// The map is stored as rows of 64 presence bits.
	localparam int WORD_BITS = 64;
	localparam int WORD_LG   = 6;

	// The divider produces one quotient bit per step.
	localparam int DIV_STEPS = POS_W;
	localparam int DIV_CNT_W = 6;

	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MARK  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_OBJ_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLK_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLK_COUNT = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WORD_LG-1:0]   bitpos_t;
	typedef logic [POS_W-1:0]     pos_t;

	typedef struct packed {
		logic                  start;
		pos_t                  dividend;
		logic [BLK_SIZE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		pos_t quot;
	} div_rsp_t;

endpackage

### design/rcbpm_ifs.sv
// Channel interfaces of the range cache block presence map.
interface rcbpm_req_if;
	logic                            valid;
	logic                            ready;
	logic [rcbpm_pkg::MODE_W-1:0]    mode;
	logic [rcbpm_pkg::POS_W-1:0]     first_pos;
	logic [rcbpm_pkg::POS_W-1:0]     last_pos;

	modport source(output valid, output mode, output first_pos, output last_pos, input ready);
	modport sink(input valid, input mode, input first_pos, input last_pos, output ready);
endinterface

interface rcbpm_rsp_if;
	logic valid;
	logic ready;
	logic all_present;

	modport source(output valid, output all_present, input ready);
	modport sink(input valid, input all_present, output ready);
endinterface

interface rcbpm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rcbpm_pkg::CFG_IDX_W-1:0]   index;
	logic [rcbpm_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

### design/range_cache_block_presence_map.sv
// Top level of the range cache block presence map: sequencer, registers and map storage.
//
// The block keeps one presence bit per block of a cached object, stored as rows of
// 64 bits in a single RAM. It handles one transaction at a time and is not ready
// while it works. A query takes two passes of the shared 40-step divider and then
// reads each 64-bit map row that the range touches; it stops at the first row
// with a missing block. A query that falls outside the object or has a reversed
// range or zero block size answers without using the divider. A mark reads and
// then writes back each row that it touches. A clear sweeps every row, one per
// cycle. After reset the same clearing pass runs before the first transaction is
// accepted; configuration writes are taken at any time. Every transaction returns
// exactly one result, which sits in an output register, so the next transaction
// can be accepted while that result still waits to be taken.
module range_cache_block_presence_map #(
	parameter int MAX_BLOCKS = rcbpm_pkg::MAX_BLOCKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rcbpm_req_if.sink         req,
	rcbpm_rsp_if.source       rsp,
	rcbpm_cfg_if.sink         cfg
);

	localparam int ROWS   = (MAX_BLOCKS + rcbpm_pkg::WORD_BITS - 1) / rcbpm_pkg::WORD_BITS;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W  = ROW_AW + rcbpm_pkg::WORD_LG;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_PREP   = 3'd2;
	localparam logic [2:0] ST_DIV_LO = 3'd3;
	localparam logic [2:0] ST_DIV_HI = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;
	localparam logic [2:0] ST_CHECK  = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	logic [2:0]                             state_q;
	logic [rcbpm_pkg::MODE_W-1:0]           mode_q;
	rcbpm_pkg::pos_t                        first_q;
	rcbpm_pkg::pos_t                        last_q;
	logic [IDX_W-1:0]                       lo_q;
	logic [IDX_W-1:0]                       hi_q;
	logic [ROW_AW-1:0]                      row_q;
	logic                                   hit_q;
	logic                                   clr_item_q;
	logic                                   out_valid_q;
	logic                                   out_hit_q;
	logic [rcbpm_pkg::OBJ_SIZE_W-1:0]       obj_size_q;
	logic [rcbpm_pkg::BLK_SIZE_W-1:0]       blk_size_q;
	logic [rcbpm_pkg::BLK_COUNT_W-1:0]      blk_count_q;

	rcbpm_pkg::div_req_t                    div_req;
	rcbpm_pkg::div_rsp_t                    div_rsp;

	rcbpm_pkg::pos_t                        n_blocks;
	rcbpm_pkg::pos_t                        n_last;
	rcbpm_pkg::pos_t                        mark_hi;
	logic                                   query_bad;
	logic                                   mark_none;
	logic                                   last_row;

	rcbpm_pkg::bitpos_t                     lo_bit;
	rcbpm_pkg::bitpos_t                     hi_bit;
	rcbpm_pkg::word_t                       row_mask;
	rcbpm_pkg::word_t                       rdata;
	rcbpm_pkg::word_t                       wdata;
	logic                                   ram_we;
	logic                                   ram_re;

	// Configuration registers. Writes are only expected while the block is idle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_size_q  <= rcbpm_pkg::OBJ_SIZE_W'(1);
			blk_size_q  <= rcbpm_pkg::BLK_SIZE_W'(1);
			blk_count_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rcbpm_pkg::CFG_OBJ_SIZE: begin
					obj_size_q <= cfg.data[rcbpm_pkg::OBJ_SIZE_W-1:0];
				end
				rcbpm_pkg::CFG_BLK_SIZE: begin
					blk_size_q <= cfg.data[rcbpm_pkg::BLK_SIZE_W-1:0];
				end
				rcbpm_pkg::CFG_BLK_COUNT: begin
					blk_count_q <= cfg.data[rcbpm_pkg::BLK_COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Blocks in use: the configured count, limited to what the map can hold.
	assign n_blocks = (rcbpm_pkg::POS_W'(blk_count_q) > rcbpm_pkg::POS_W'(MAX_BLOCKS))
		? rcbpm_pkg::POS_W'(MAX_BLOCKS) : rcbpm_pkg::POS_W'(blk_count_q);
	assign n_last   = n_blocks - rcbpm_pkg::POS_W'(1);

	// A query misses at once when it reaches past the object, is reversed, or the
	// block size is zero.
	assign query_bad = ({1'b0, last_q} >= obj_size_q) || (first_q > last_q)
		|| (blk_size_q == '0);

	// A mark is clipped to the blocks in use; nothing is left if it starts past them.
	assign mark_none = (n_blocks == '0) || (first_q > last_q) || (first_q > n_last);
	assign mark_hi   = (last_q > n_last) ? n_last : last_q;

	// Bits of the current row that the block range covers.
	always_comb begin
		lo_bit = (row_q == lo_q[IDX_W-1:rcbpm_pkg::WORD_LG])
			? lo_q[rcbpm_pkg::WORD_LG-1:0] : '0;
		hi_bit = (row_q == hi_q[IDX_W-1:rcbpm_pkg::WORD_LG])
			? hi_q[rcbpm_pkg::WORD_LG-1:0] : '1;
		for (int j = 0; j < rcbpm_pkg::WORD_BITS; j++) begin
			row_mask[j] = (rcbpm_pkg::bitpos_t'(j) >= lo_bit)
				&& (rcbpm_pkg::bitpos_t'(j) <= hi_bit);
		end
	end

	assign last_row = (row_q == hi_q[IDX_W-1:rcbpm_pkg::WORD_LG]);

	// The divider takes the first byte when leaving the decode step and the last byte
	// as soon as the first quotient is in.
	assign div_req.start    = ((state_q == ST_PREP) && (mode_q == rcbpm_pkg::MODE_QUERY)
		&& !query_bad) || ((state_q == ST_DIV_LO) && div_rsp.done);
	assign div_req.dividend = (state_q == ST_PREP) ? first_q : last_q;
	assign div_req.divisor  = blk_size_q;

	rcbpm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Map storage: zero rows during a clearing pass, read-modify-write for a mark.
	assign ram_re = (state_q == ST_READ);
	assign ram_we = (state_q == ST_CLEAR)
		|| ((state_q == ST_CHECK) && (mode_q == rcbpm_pkg::MODE_MARK));
	assign wdata  = (state_q == ST_CLEAR) ? '0 : (rdata | row_mask);

	rcbpm_ram #(
		.WIDTH (rcbpm_pkg::WORD_BITS),
		.DEPTH (ROWS),
		.AW    (ROW_AW)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_q),
		.wdata (wdata),
		.re    (ram_re),
		.raddr (row_q),
		.rdata (rdata)
	);

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.all_present = out_hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			row_q       <= '0;
			clr_item_q  <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
		end else begin
			// The done step reloads the output register itself.
			if (out_valid_q && rsp.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (row_q == ROW_AW'(ROWS - 1)) begin
						row_q <= '0;
						hit_q <= 1'b0;
						state_q <= clr_item_q ? ST_DONE : ST_IDLE;
					end else begin
						row_q <= row_q + ROW_AW'(1);
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					hit_q <= 1'b0;
					priority if (mode_q == rcbpm_pkg::MODE_QUERY) begin
						state_q <= query_bad ? ST_DONE : ST_DIV_LO;
					end else if (mode_q == rcbpm_pkg::MODE_MARK) begin
						row_q   <= first_q[IDX_W-1:rcbpm_pkg::WORD_LG];
						state_q <= mark_none ? ST_DONE : ST_READ;
					end else if (mode_q == rcbpm_pkg::MODE_CLEAR) begin
						row_q      <= '0;
						clr_item_q <= 1'b1;
						state_q    <= ST_CLEAR;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV_LO: begin
					if (div_rsp.done) begin
						state_q <= ST_DIV_HI;
					end
				end
				ST_DIV_HI: begin
					if (div_rsp.done) begin
						if (div_rsp.quot >= n_blocks) begin
							state_q <= ST_DONE;
						end else begin
							row_q   <= lo_q[IDX_W-1:rcbpm_pkg::WORD_LG];
							hit_q   <= 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if ((mode_q == rcbpm_pkg::MODE_QUERY) && ((rdata & row_mask) != row_mask)) begin
						hit_q   <= 1'b0;
						state_q <= ST_DONE;
					end else if (last_row) begin
						state_q <= ST_DONE;
					end else begin
						row_q   <= row_q + ROW_AW'(1);
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					// Hand the result over once the output register is free.
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_hit_q   <= hit_q;
						clr_item_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item fields and block range bounds; these need no reset.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && req.valid) begin
			mode_q  <= req.mode;
			first_q <= req.first_pos;
			last_q  <= req.last_pos;
		end
		if ((state_q == ST_PREP) && (mode_q == rcbpm_pkg::MODE_MARK)) begin
			lo_q <= first_q[IDX_W-1:0];
			hi_q <= mark_hi[IDX_W-1:0];
		end
		if ((state_q == ST_DIV_LO) && div_rsp.done) begin
			lo_q <= div_rsp.quot[IDX_W-1:0];
		end
		if ((state_q == ST_DIV_HI) && div_rsp.done) begin
			hi_q <= div_rsp.quot[IDX_W-1:0];
		end
	end

endmodule

### design/rcbpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rcbpm_ram #(
	parameter int WIDTH = rcbpm_pkg::WORD_BITS,
	parameter int DEPTH = rcbpm_pkg::MAX_BLOCKS_DEF / rcbpm_pkg::WORD_BITS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/rcbpm_div.sv
// Restoring divider that yields one quotient bit per clock cycle.
module rcbpm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rcbpm_pkg::div_req_t req,
	output rcbpm_pkg::div_rsp_t rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [rcbpm_pkg::DIV_CNT_W-1:0]     cnt_q;
	rcbpm_pkg::pos_t                     dq_q;
	logic [rcbpm_pkg::BLK_SIZE_W-1:0]    rem_q;
	logic [rcbpm_pkg::BLK_SIZE_W-1:0]    div_q;
	logic [rcbpm_pkg::BLK_SIZE_W:0]      trial;
	logic                                fits;

	// Shift in the next dividend bit and try the subtraction.
	assign trial = {rem_q, dq_q[rcbpm_pkg::POS_W-1]};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// Done is raised for one cycle after the last step.
			done_q <= busy_q && !req.start
				&& (cnt_q == rcbpm_pkg::DIV_CNT_W'(rcbpm_pkg::DIV_STEPS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + rcbpm_pkg::DIV_CNT_W'(1);
				if (cnt_q == rcbpm_pkg::DIV_CNT_W'(rcbpm_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[rcbpm_pkg::POS_W-2:0], fits};
			rem_q <= fits ? rcbpm_pkg::BLK_SIZE_W'(trial - {1'b0, div_q})
				: trial[rcbpm_pkg::BLK_SIZE_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dq_q;

endmodule

### design/rcbpm_checker.sv
// Port-level checks of the range cache block presence map, bound to the top level.
module rcbpm_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_all_present,
	input logic cfg_valid,
	input logic cfg_ready
);

	// The block works on one transaction at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while a previous one was in progress");

	// A result appears only after the block has been busy with a transaction.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result produced without a transaction in progress");

	// Configuration writes are always taken.
	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

	// A stalled result keeps its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_all_present)))
		else $error("stalled result changed or dropped");

endmodule

bind range_cache_block_presence_map rcbpm_checker u_rcbpm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_all_present (rsp.all_present),
	.cfg_valid       (cfg.valid),
	.cfg_ready       (cfg.ready)
);

### test/tb.sv
// Self-checking testbench for the range cache block presence map.
`timescale 1ns / 1ps

module tb;

	// Codes that the package leaves unnamed: the spare mode and the spare register index.
	localparam logic [rcbpm_pkg::MODE_W-1:0]    MODE_SPARE = 2'd3;
	localparam logic [rcbpm_pkg::CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

	localparam int          MAX_BLK   = rcbpm_pkg::MAX_BLOCKS_DEF;
	localparam longint      POS_MASK  = 64'hFF_FFFF_FFFF;
	localparam longint      OBJ_MASK  = 64'h1FF_FFFF_FFFF;
	localparam int          HOLD_LEN  = 300;
	localparam int          TAIL_WAIT = 250;
	localparam int          PHASES    = 14;
	localparam int          PER_PHASE = 125;

	// One row of the directed table: either a register load or one request transaction.
	typedef struct {
		bit                                     is_cfg;
		logic [rcbpm_pkg::MODE_W-1:0]           mode;
		logic [rcbpm_pkg::POS_W-1:0]            lo_pos;
		logic [rcbpm_pkg::POS_W-1:0]            hi_pos;
		bit                                     typed;
		logic                                   want;
		logic [rcbpm_pkg::CFG_DATA_W-1:0]       obj;
		logic [rcbpm_pkg::CFG_DATA_W-1:0]       bsz;
		logic [rcbpm_pkg::CFG_DATA_W-1:0]       bcnt;
		bit                                     stray;
	} step_row_t;

	logic clk;
	logic arst_n;

	rcbpm_req_if req_ch();
	rcbpm_rsp_if rsp_ch();
	rcbpm_cfg_if cfg_ch();

	range_cache_block_presence_map dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the registers and of the presence bits, kept in step with the
	// transactions that the block has accepted.
	logic [rcbpm_pkg::OBJ_SIZE_W-1:0]  obj_size_r;
	logic [rcbpm_pkg::BLK_SIZE_W-1:0]  blk_size_r;
	logic [rcbpm_pkg::BLK_COUNT_W-1:0] blk_count_r;
	bit                                shadow_map [MAX_BLK];

	// Expected all_present values, oldest first, one per accepted request.
	logic all_present_q [$];

	// The directed table, in the order it is applied.
	step_row_t rows [$];

	int fail_count;

	// Shared between the request driver and the response side.
	bit idle_on;
	bit want_hold;

	// Hint for the random generator: the last block range that a mark set.
	bit          have_mark;
	longint unsigned mark_lo;
	longint unsigned mark_hi;

	always #1 clk = ~clk;

	// Global time limit, well beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("range_cache_block_presence_map regression: fail");
		$finish;
	end

	function automatic longint unsigned rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic longint unsigned blocks_in_use();
		return (blk_count_r > MAX_BLK) ? MAX_BLK : blk_count_r;
	endfunction

	// Applies one request to the shadow state and returns the answer that the block
	// must give for it. A query looks at every block the byte range touches; a mark
	// sets a block range clipped to the blocks in use; a clear empties the map.
	function automatic logic compute_all_present(logic [rcbpm_pkg::MODE_W-1:0] mode,
			logic [rcbpm_pkg::POS_W-1:0] lo_pos, logic [rcbpm_pkg::POS_W-1:0] hi_pos);
		longint unsigned n, lo_blk, hi_blk, b, top;
		logic hit;
		hit = 1'b0;
		n = blocks_in_use();
		case (mode)
			rcbpm_pkg::MODE_QUERY: begin
				if (hi_pos < obj_size_r && lo_pos <= hi_pos && blk_size_r != 0) begin
					lo_blk = longint'(lo_pos) / longint'(blk_size_r);
					hi_blk = longint'(hi_pos) / longint'(blk_size_r);
					if (hi_blk < n) begin
						hit = 1'b1;
						for (b = lo_blk; b <= hi_blk && hit; b++)
							if (!shadow_map[b])
								hit = 1'b0;
					end
				end
			end
			rcbpm_pkg::MODE_MARK: begin
				if (n != 0 && lo_pos <= hi_pos) begin
					top = (hi_pos > n - 1) ? n - 1 : hi_pos;
					for (b = lo_pos; b <= top; b++)
						shadow_map[b] = 1'b1;
				end
			end
			rcbpm_pkg::MODE_CLEAR: begin
				foreach (shadow_map[i])
					shadow_map[i] = 1'b0;
			end
			default: ;
		endcase
		return hit;
	endfunction

	task automatic note_failure(string what, logic want, logic got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s: expected all_present %b, got %b", $realtime, what, want, got);
	endtask

	// Writes one register and mirrors it in the shadow copy. The valid is left high so
	// that back-to-back writes never lower and raise it within one time step.
	task automatic put_reg(logic [rcbpm_pkg::CFG_IDX_W-1:0] idx,
			logic [rcbpm_pkg::CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			rcbpm_pkg::CFG_OBJ_SIZE:  obj_size_r  = val[rcbpm_pkg::OBJ_SIZE_W-1:0];
			rcbpm_pkg::CFG_BLK_SIZE:  blk_size_r  = val[rcbpm_pkg::BLK_SIZE_W-1:0];
			rcbpm_pkg::CFG_BLK_COUNT: blk_count_r = val[rcbpm_pkg::BLK_COUNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_regs(logic [rcbpm_pkg::CFG_DATA_W-1:0] obj,
			logic [rcbpm_pkg::CFG_DATA_W-1:0] bsz,
			logic [rcbpm_pkg::CFG_DATA_W-1:0] bcnt, bit stray);
		put_reg(rcbpm_pkg::CFG_OBJ_SIZE, obj);
		put_reg(rcbpm_pkg::CFG_BLK_SIZE, bsz);
		if (stray)
			put_reg(CFG_SPARE, rcbpm_pkg::CFG_DATA_W'(rand64()));
		put_reg(rcbpm_pkg::CFG_BLK_COUNT, bcnt);
		cfg_ch.valid <= 1'b0;
	endtask

	// Stops offering requests and waits until every expected response has been taken.
	// Each request yields one response, so the block is idle once the queue is empty.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (all_present_q.size() != 0)
			@(posedge clk);
	endtask

	// Offers one request, sometimes after a short idle burst, and records the expected
	// answer at the edge where the block accepts it.
	task automatic offer(logic [rcbpm_pkg::MODE_W-1:0] mode,
			logic [rcbpm_pkg::POS_W-1:0] lo_pos, logic [rcbpm_pkg::POS_W-1:0] hi_pos,
			bit typed, logic want);
		logic predicted;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7))
				@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.mode      <= mode;
		req_ch.first_pos <= lo_pos;
		req_ch.last_pos  <= hi_pos;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predicted = compute_all_present(mode, lo_pos, hi_pos);
		all_present_q.insert(all_present_q.size(), typed ? want : predicted);
	endtask

	// Picks a fresh register setting. Most settings are consistent (block count is the
	// ceiling of object size over block size), some are not, and a few carry junk above
	// the register widths.
	task automatic random_settings();
		longint unsigned bsz, obj, bcnt, blocks;
		logic [rcbpm_pkg::CFG_DATA_W-1:0] bsz_word, bcnt_word;
		case ($urandom_range(0, 9))
			0, 1, 2: bsz = $urandom_range(1, 16);
			3, 4:    bsz = 64'd1 << $urandom_range(0, 32);
			5:       bsz = $urandom_range(1, 100000);
			6:       bsz = rand64() & 64'h1_FFFF_FFFF;
			7:       bsz = 64'h1_FFFF_FFFF;
			8:       bsz = 0;
			default: bsz = $urandom_range(17, 4096);
		endcase
		if ($urandom_range(0, 3) == 0)
			blocks = $urandom_range(1, MAX_BLK);
		else
			blocks = $urandom_range(1, 200);
		if (bsz == 0 || $urandom_range(0, 9) == 0) begin
			obj = rand64() & OBJ_MASK;
		end else begin
			obj = blocks * bsz - rand64() % bsz;
			if (obj > OBJ_MASK)
				obj = OBJ_MASK;
		end
		if (bsz == 0 || obj == 0 || $urandom_range(0, 7) == 0) begin
			bcnt = $urandom_range(0, 8191);
		end else begin
			bcnt = (obj + bsz - 1) / bsz;
			if (bcnt > MAX_BLK)
				bcnt = MAX_BLK;
		end
		bsz_word  = rcbpm_pkg::CFG_DATA_W'(bsz);
		bcnt_word = rcbpm_pkg::CFG_DATA_W'(bcnt);
		if ($urandom_range(0, 3) == 0)
			bsz_word[rcbpm_pkg::CFG_DATA_W-1:rcbpm_pkg::BLK_SIZE_W] =
				(rcbpm_pkg::CFG_DATA_W - rcbpm_pkg::BLK_SIZE_W)'($urandom);
		if ($urandom_range(0, 3) == 0)
			bcnt_word[rcbpm_pkg::CFG_DATA_W-1:rcbpm_pkg::BLK_COUNT_W] =
				(rcbpm_pkg::CFG_DATA_W - rcbpm_pkg::BLK_COUNT_W)'($urandom);
		load_regs(rcbpm_pkg::CFG_DATA_W'(obj), bsz_word, bcnt_word,
			$urandom_range(0, 3) == 0);
		have_mark = 1'b0;
	endtask

	// One random request. Most are well formed: queries that land on recently marked
	// blocks, queries inside the object, and marks within the blocks in use. The rest
	// are clears and fully random noise, reversed ranges and the spare mode among them.
	task automatic random_item();
		logic [rcbpm_pkg::MODE_W-1:0] mode;
		longint unsigned lo_pos, hi_pos, n, a, b, pick, tmp;
		n = blocks_in_use();
		pick = $urandom_range(0, 99);
		mode = rcbpm_pkg::MODE_QUERY;
		lo_pos = 0;
		hi_pos = 0;
		if (pick < 35 && have_mark && blk_size_r != 0) begin
			a = mark_lo + rand64() % (mark_hi - mark_lo + 1);
			b = a + rand64() % (mark_hi - a + 1);
			lo_pos = a * blk_size_r + rand64() % blk_size_r;
			hi_pos = b * blk_size_r + rand64() % blk_size_r;
			if (lo_pos > hi_pos) begin
				tmp = lo_pos;
				lo_pos = hi_pos;
				hi_pos = tmp;
			end
		end else if (pick < 55 && obj_size_r != 0) begin
			lo_pos = rand64() % obj_size_r;
			if ($urandom_range(0, 1))
				hi_pos = lo_pos + rand64() % (longint'(blk_size_r) * 4 + 1);
			else
				hi_pos = lo_pos + rand64() % (obj_size_r - lo_pos + 1);
		end else if (pick < 80) begin
			mode = rcbpm_pkg::MODE_MARK;
			lo_pos = rand64() % (n + 1);
			case ($urandom_range(0, 3))
				0:       hi_pos = lo_pos + rand64() % (n + 1);
				1:       hi_pos = rand64();
				default: hi_pos = lo_pos + $urandom_range(0, 63);
			endcase
			lo_pos &= POS_MASK;
			hi_pos &= POS_MASK;
			if (n != 0 && lo_pos < n && lo_pos <= hi_pos) begin
				mark_lo = lo_pos;
				mark_hi = (hi_pos < n) ? hi_pos : n - 1;
				have_mark = 1'b1;
			end
		end else if (pick < 85) begin
			mode = rcbpm_pkg::MODE_CLEAR;
			have_mark = 1'b0;
		end else begin
			mode = rcbpm_pkg::MODE_W'($urandom_range(0, 3));
			lo_pos = rand64();
			hi_pos = rand64();
		end
		offer(mode, lo_pos[rcbpm_pkg::POS_W-1:0], hi_pos[rcbpm_pkg::POS_W-1:0], 1'b0, 1'b0);
	endtask

	function automatic step_row_t op_row(logic [rcbpm_pkg::MODE_W-1:0] mode,
			logic [rcbpm_pkg::POS_W-1:0] lo_pos, logic [rcbpm_pkg::POS_W-1:0] hi_pos,
			bit typed = 1'b0, logic want = 1'b0);
		step_row_t r;
		r = '{default: '0};
		r.mode   = mode;
		r.lo_pos = lo_pos;
		r.hi_pos = hi_pos;
		r.typed  = typed;
		r.want   = want;
		return r;
	endfunction

	function automatic step_row_t cfg_row(logic [rcbpm_pkg::CFG_DATA_W-1:0] obj,
			logic [rcbpm_pkg::CFG_DATA_W-1:0] bsz, logic [rcbpm_pkg::CFG_DATA_W-1:0] bcnt,
			bit stray = 1'b0);
		step_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.obj    = obj;
		r.bsz    = bsz;
		r.bcnt   = bcnt;
		r.stray  = stray;
		return r;
	endfunction

	function automatic void add_row(step_row_t r);
		rows.insert(rows.size(), r);
	endfunction

	// Response side: takes results with random stall bursts, honors one long hold-off
	// request from the driver, and compares each result with the oldest expectation.
	initial begin : response_side
		int stall_left;
		int hold_left;
		bit hold_done;
		logic want;
		stall_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (all_present_q.size() == 0) begin
					note_failure("response with nothing outstanding", 1'bx, rsp_ch.all_present);
				end else begin
					want = all_present_q.pop_front();
					if (rsp_ch.all_present !== want)
						note_failure("all_present mismatch", want, rsp_ch.all_present);
				end
			end
			if (want_hold && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Request side: reset, the directed table, the random phases and the end of run.
	initial begin : request_side
		clk = 1'b0;
		arst_n = 1'b0;
		fail_count = 0;
		idle_on = 1'b1;
		want_hold = 1'b0;
		have_mark = 1'b0;
		mark_lo = 0;
		mark_hi = 0;
		req_ch.valid = 1'b0;
		req_ch.mode = rcbpm_pkg::MODE_QUERY;
		req_ch.first_pos = '0;
		req_ch.last_pos = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = rcbpm_pkg::CFG_OBJ_SIZE;
		cfg_ch.data = '0;
		obj_size_r = 1;
		blk_size_r = 1;
		blk_count_r = 0;
		foreach (shadow_map[i])
			shadow_map[i] = 1'b0;

		// Reset values leave no block in use, so nothing can be marked or found.
		add_row(op_row(rcbpm_pkg::MODE_QUERY, 40'd0, 40'd0, 1'b1, 1'b0));
		add_row(op_row(rcbpm_pkg::MODE_MARK, 40'd0, 40'd0, 1'b1, 1'b0));
		add_row(op_row(MODE_SPARE, 40'd0, 40'd0, 1'b1, 1'b0));
		// A 2^40-byte object in 256 blocks of 2^32 bytes; also a write to the spare index.
		add_row(cfg_row(41'h100_0000_0000, 41'h1_0000_0000, 41'd256, 1'b1));
		add_row(op_row(rcbpm_pkg::MODE_MARK, 40'd0, 40'hFF_FFFF_FFFF, 1'b1, 1'b0));
		add_row(op_row(rcbpm_pkg::MODE_QUERY, 40'd0, 40'hFF_FFFF_FFFF));
		add_row(op_row(rcbpm_pkg::MODE_QUERY, 40'd5, 40'd4, 1'b1, 1'b0));
		add_row(op_row(rcbpm_pkg::MODE_CLEAR, 40'd0, 40'd0, 1'b1, 1'b0));
		add_row(op_row(rcbpm_pkg::MODE_QUERY, 40'd0, 40'd0, 1'b1, 1'b0));
		add_row(op_row(rcbpm_pkg::MODE_MARK, 40'd3, 40'd2, 1'b1, 1'b0));
		add_row(op_row(rcbpm_pkg::MODE_MARK, 40'd2, 40'd2, 1'b1, 1'b0));
		add_row(op_row(rcbpm_pkg::MODE_QUERY, 40'h2_0000_0000, 40'h2_FFFF_FFFF));
		add_row(op_row(rcbpm_pkg::MODE_QUERY, 40'h1_FFFF_FFFF, 40'h2_FFFF_FFFF));
		// A zero block size makes every query miss while marks still land.
		add_row(cfg_row(41'h100_0000_0000, 41'd0, 41'd256));
		add_row(op_row(rcbpm_pkg::MODE_QUERY, 40'd0, 40'd0, 1'b1, 1'b0));
		add_row(op_row(rcbpm_pkg::MODE_MARK, 40'd5, 40'd9, 1'b1, 1'b0));
		// An empty object misses always; a block count past the map size is clipped.
		add_row(cfg_row(41'd0, 41'd1, 41'd8191));
		add_row(op_row(rcbpm_pkg::MODE_QUERY, 40'd0, 40'd0, 1'b1, 1'b0));
		add_row(cfg_row(41'd100, 41'd1, 41'd8191));
		add_row(op_row(rcbpm_pkg::MODE_QUERY, 40'd5, 40'd9));
		add_row(op_row(rcbpm_pkg::MODE_QUERY, 40'd99, 40'd100, 1'b1, 1'b0));
		add_row(op_row(rcbpm_pkg::MODE_QUERY, 40'd99, 40'd99));
		add_row(op_row(rcbpm_pkg::MODE_MARK, 40'd0, 40'd4095, 1'b1, 1'b0));
		// All-ones register values.
		add_row(cfg_row(41'h1FF_FFFF_FFFF, 41'h1_FFFF_FFFF, 41'd8191));
		add_row(op_row(rcbpm_pkg::MODE_QUERY, 40'd0, 40'hFF_FFFF_FFFF));
		add_row(op_row(rcbpm_pkg::MODE_MARK, 40'd4094, 40'hFF_FFFF_FFFF, 1'b1, 1'b0));
		add_row(op_row(MODE_SPARE, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1, 1'b0));
		// One byte per block over the full map: the last block hits, one past it misses.
		add_row(cfg_row(41'h100_0000_0000, 41'd1, 41'd4096));
		add_row(op_row(rcbpm_pkg::MODE_QUERY, 40'd4095, 40'd4095));
		add_row(op_row(rcbpm_pkg::MODE_QUERY, 40'd4096, 40'd4096, 1'b1, 1'b0));

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[k]) begin
			if (rows[k].is_cfg) begin
				drain();
				load_regs(rows[k].obj, rows[k].bsz, rows[k].bcnt, rows[k].stray);
			end else begin
				offer(rows[k].mode, rows[k].lo_pos, rows[k].hi_pos, rows[k].typed,
					rows[k].want);
			end
		end

		// Random phases, each under a fresh setting written while the block is idle.
		// The second phase starts with the long hold-off on the response side so that
		// the output register fills and the block stops taking requests; the final
		// phase runs with no idling on either side.
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			random_settings();
			if (phase == 1)
				want_hold = 1'b1;
			if (phase == PHASES - 1)
				idle_on = 1'b0;
			repeat (PER_PHASE)
				random_item();
		end

		drain();
		repeat (TAIL_WAIT)
			@(posedge clk);
		if (fail_count == 0 && all_present_q.size() == 0)
			$display("range_cache_block_presence_map regression: pass");
		else
			$display("range_cache_block_presence_map regression: fail");
		$finish;
	end

endmodule
